// ----- sv/assert_macros.svh -----
// assertion macros used by the encoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock edge, off while in reset
`define B58_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define B58_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define B58_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/b58_pkg.sv -----
// shared constants and the base58 alphabet lookup
package b58_pkg;

   localparam int MaxBytesDefault  = 32;
   localparam int MaxDigitsDefault = 44;

   localparam logic [6:0] Radix   = 7'd58;
   localparam logic [6:0] CharOne = 7'd49;

   // digit value to ascii code, alphabet without 0, O, I and l
   function automatic logic [6:0] b58_char(input logic [5:0] digit);
      logic [6:0] d7;
      d7 = {1'b0, digit};
      if (digit < 6'd9) begin
         b58_char = CharOne + d7;
      end else if (digit < 6'd17) begin
         b58_char = 7'd65 + (d7 - 7'd9);
      end else if (digit < 6'd22) begin
         b58_char = 7'd74 + (d7 - 7'd17);
      end else if (digit < 6'd33) begin
         b58_char = 7'd80 + (d7 - 7'd22);
      end else if (digit < 6'd44) begin
         b58_char = 7'd97 + (d7 - 7'd33);
      end else begin
         b58_char = 7'd109 + (d7 - 7'd44);
      end
   endfunction

endpackage

// ----- sv/b58_if.sv -----
// valid/ready channel interfaces for the byte input and character output
interface b58_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b58_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       last_char;
   logic       overflow;

   modport source (output valid, output char_code, output last_char, output overflow,
                   input ready);
   modport sink (input valid, input char_code, input last_char, input overflow,
                 output ready);
endinterface

// ----- sv/b58_divstep.sv -----
// one long-division step: (remainder * 256 + byte) divided by 58
module b58_divstep (
   input  logic [5:0] rem_in,
   input  logic [7:0] byte_in,
   output logic [7:0] quot,
   output logic [5:0] rem_out
);

   logic [6:0] r_work;
   logic [7:0] q_work;

   // restoring division, one quotient bit per step, remainder stays below 58
   always_comb begin
      r_work = {1'b0, rem_in};
      q_work = '0;
      for (int i = 7; i >= 0; i--) begin
         r_work = {r_work[5:0], byte_in[i]};
         if (r_work >= b58_pkg::Radix) begin
            r_work    = r_work - b58_pkg::Radix;
            q_work[i] = 1'b1;
         end
      end
   end

   assign quot    = q_work;
   assign rem_out = r_work[5:0];

endmodule

// ----- sv/base58_encoder.sv -----
// base58 encoder top level: byte store, division sequencer and character output
//
// req_bus takes one byte of the big-endian string per transaction, last_byte
// marking the final byte. After a byte that is not last, ready stays high.
// Bytes past MAX_BYTES are dropped and flag overflow on every character of
// that encoding. On the last byte, req_bus.ready falls and the block converts
// the stored number by repeated long division by 58, one stored byte per
// cycle through a single shared divide step; each pass yields one digit, so
// a 25-byte string gives up to 35 digits.
// The characters then leave on rsp_bus, most significant first: one '1' per
// leading zero byte, then the alphabet characters, the final one marked
// last_char. Each character steps through S_EMIT_RD, S_EMIT_LD, S_EMIT_OUT,
// waiting while rsp_bus.ready is low, held unchanged in the output register.
// req_bus.ready rises again the cycle after the final character is taken.
// Reset (synchronous, active high) clears the counters and flags and returns
// to idle; the byte and digit memories are not cleared and need no sweep.
`include "assert_macros.svh"

module base58_encoder #(
   parameter int MAX_BYTES  = b58_pkg::MaxBytesDefault,
   parameter int MAX_DIGITS = b58_pkg::MaxDigitsDefault
) (
   input  logic      clock,
   input  logic      reset,
   b58_req_if.sink   req_bus,
   b58_rsp_if.source rsp_bus
);

   // sizes derived from the parameters
   localparam int SCRATCH = 2 * MAX_BYTES + 2;       // digit scratch depth
   localparam int AW      = $clog2(MAX_BYTES);       // byte store address
   localparam int BC_W    = $clog2(MAX_BYTES + 1);   // byte count
   localparam int DA_W    = $clog2(SCRATCH);         // digit store address
   localparam int ND_W    = $clog2(SCRATCH + 1);     // digit count
   localparam int TOT_W   = ND_W + 1;                // leading ones plus digits
   localparam int K_W     = $clog2(MAX_DIGITS + 1);  // emitted character count

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CHECK    = 3'd1;
   localparam logic [2:0] S_DIV      = 3'd2;
   localparam logic [2:0] S_EMIT_RD  = 3'd3;
   localparam logic [2:0] S_EMIT_LD  = 3'd4;
   localparam logic [2:0] S_EMIT_OUT = 3'd5;

   logic [2:0]      state_ff, state_in;
   logic [BC_W-1:0] byte_count_ff, byte_count_in;
   logic [BC_W-1:0] zero_run_ff, zero_run_in;
   logic            ovf_flag_ff, ovf_flag_in;
   logic            nonzero_ff, nonzero_in;     // working value not yet zero
   logic            acc_nz_ff, acc_nz_in;       // any non-zero quotient byte this pass
   logic [AW-1:0]   idx_ff, idx_in;
   logic [5:0]      rem_ff, rem_in;
   logic [ND_W-1:0] nd_ff, nd_in;
   logic [K_W-1:0]  k_ff, k_in;
   logic [K_W-1:0]  total_ff, total_in;
   logic            ovf_out_ff, ovf_out_in;
   logic [6:0]      char_ff, char_in;
   logic            last_ff, last_in;

   // byte store, rewritten in place with the quotient on every pass
   logic [7:0]      byte_mem [MAX_BYTES];
   logic            byte_we;
   logic [AW-1:0]   byte_waddr;
   logic [7:0]      byte_wdata;
   logic [AW-1:0]   byte_raddr;
   logic [7:0]      byte_rdata_ff;

   // digit scratch, least significant digit first
   logic [5:0]      dig_mem [SCRATCH];
   logic            dig_we;
   logic [DA_W-1:0] dig_raddr;
   logic [5:0]      dig_rdata_ff;

   logic            req_fire;
   logic            room;
   logic [7:0]      quot;
   logic [5:0]      rem_next;
   logic            pass_end;
   logic [TOT_W-1:0] sum_chars;
   logic [TOT_W-1:0] dig_pos;
   logic            is_one;

   b58_divstep u_divstep (
      .rem_in  (rem_ff),
      .byte_in (byte_rdata_ff),
      .quot    (quot),
      .rem_out (rem_next)
   );

   assign req_fire = req_bus.valid && req_bus.ready;
   assign room     = byte_count_ff < BC_W'(MAX_BYTES);
   assign pass_end = (BC_W'(idx_ff) + BC_W'(1)) == byte_count_ff;

   assign sum_chars = TOT_W'(zero_run_ff) + TOT_W'(nd_ff);
   // digit taken from the top of the scratch down
   assign dig_pos   = TOT_W'(nd_ff) + TOT_W'(zero_run_ff) - TOT_W'(1) - TOT_W'(k_ff);
   assign dig_raddr = dig_pos[DA_W-1:0];
   assign is_one    = TOT_W'(k_ff) < TOT_W'(zero_run_ff);

   assign dig_we = (state_ff == S_DIV) && pass_end;

   // handshake outputs
   assign req_bus.ready     = state_ff == S_IDLE;
   assign rsp_bus.valid     = state_ff == S_EMIT_OUT;
   assign rsp_bus.char_code = char_ff;
   assign rsp_bus.last_char = last_ff;
   assign rsp_bus.overflow  = ovf_out_ff;

   // byte store port selection: load in idle, quotient write-back during a pass
   always_comb begin
      byte_we    = 1'b0;
      byte_waddr = byte_count_ff[AW-1:0];
      byte_wdata = req_bus.data_byte;
      byte_raddr = '0;
      if (state_ff == S_IDLE) begin
         byte_we = req_fire && room;
      end else if (state_ff == S_DIV) begin
         byte_we    = 1'b1;
         byte_waddr = idx_ff;
         byte_wdata = quot;
         byte_raddr = idx_ff + AW'(1);
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      byte_count_in = byte_count_ff;
      zero_run_in   = zero_run_ff;
      ovf_flag_in   = ovf_flag_ff;
      nonzero_in    = nonzero_ff;
      acc_nz_in     = acc_nz_ff;
      idx_in        = idx_ff;
      rem_in        = rem_ff;
      nd_in         = nd_ff;
      k_in          = k_ff;
      total_in      = total_ff;
      ovf_out_in    = ovf_out_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (room) begin
                  byte_count_in = byte_count_ff + BC_W'(1);
                  if (req_bus.data_byte == 8'd0 && zero_run_ff == byte_count_ff) begin
                     zero_run_in = zero_run_ff + BC_W'(1);
                  end
               end else begin
                  ovf_flag_in = 1'b1;
               end
               if (req_bus.last_byte) begin
                  nonzero_in = zero_run_in != byte_count_in;
                  state_in   = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (nonzero_ff) begin
               // start a pass, byte 0 is being read this cycle
               idx_in    = '0;
               rem_in    = '0;
               acc_nz_in = 1'b0;
               state_in  = S_DIV;
            end else begin
               k_in = '0;
               if (sum_chars > TOT_W'(MAX_DIGITS)) begin
                  total_in   = K_W'(MAX_DIGITS);
                  ovf_out_in = 1'b1;
               end else begin
                  total_in   = sum_chars[K_W-1:0];
                  ovf_out_in = ovf_flag_ff;
               end
               state_in = S_EMIT_RD;
            end
         end
         S_DIV: begin
            rem_in    = rem_next;
            acc_nz_in = acc_nz_ff || (quot != 8'd0);
            if (pass_end) begin
               nd_in      = nd_ff + ND_W'(1);
               nonzero_in = acc_nz_in;
               state_in   = S_CHECK;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            char_in  = is_one ? b58_pkg::CharOne : b58_pkg::b58_char(dig_rdata_ff);
            last_in  = (k_ff + K_W'(1)) == total_ff;
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (rsp_bus.ready) begin
               if (last_ff) begin
                  // string done, start afresh
                  byte_count_in = '0;
                  zero_run_in   = '0;
                  ovf_flag_in   = 1'b0;
                  nd_in         = '0;
                  state_in      = S_IDLE;
               end else begin
                  k_in     = k_ff + K_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         byte_count_ff <= '0;
         zero_run_ff   <= '0;
         ovf_flag_ff   <= 1'b0;
         nonzero_ff    <= 1'b0;
         acc_nz_ff     <= 1'b0;
         nd_ff         <= '0;
         k_ff          <= '0;
         total_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         zero_run_ff   <= zero_run_in;
         ovf_flag_ff   <= ovf_flag_in;
         nonzero_ff    <= nonzero_in;
         acc_nz_ff     <= acc_nz_in;
         nd_ff         <= nd_in;
         k_ff          <= k_in;
         total_ff      <= total_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      rem_ff     <= rem_in;
      ovf_out_ff <= ovf_out_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   // byte store
   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[byte_waddr] <= byte_wdata;
      end
      byte_rdata_ff <= byte_mem[byte_raddr];
   end

   // digit scratch, remainder of each pass written at the digit count
   always_ff @(posedge clock) begin
      if (dig_we) begin
         dig_mem[nd_ff[DA_W-1:0]] <= rem_next;
      end
      dig_rdata_ff <= dig_mem[dig_raddr];
   end

   // checks
   `B58_ASSERT(a_zero_run_bound, clock, reset, zero_run_ff <= byte_count_ff,
      "leading zero count exceeds stored byte count")
   `B58_ASSERT(a_count_bound, clock, reset, byte_count_ff <= BC_W'(MAX_BYTES),
      "byte count beyond store size")
   `B58_ASSERT_IMP(a_no_overlap, clock, reset, req_bus.ready, !rsp_bus.valid,
      "input taken while a character is pending")
   `B58_ASSERT_IMP(a_emit_range, clock, reset, rsp_bus.valid,
      k_ff < total_ff && total_ff <= K_W'(MAX_DIGITS), "character index out of range")
   `B58_ASSERT_NXT(a_end_idle, clock, reset,
      rsp_bus.valid && rsp_bus.ready && rsp_bus.last_char,
      req_bus.ready && byte_count_ff == '0, "no return to idle after final character")

endmodule

// ----- tb/b58_char_checker.sv -----
// character checker for the base58 encoder: tracks the byte string, predicts and compares
`timescale 1ns / 100ps

module b58_char_checker #(
   parameter int MAX_BYTES  = b58_pkg::MaxBytesDefault,
   parameter int MAX_DIGITS = b58_pkg::MaxDigitsDefault
) (
   input  logic clock,
   input  logic reset,
   b58_req_if   req_mon,
   b58_rsp_if   rsp_mon,
   output int   fail_count,
   output int   chars_owed
);

   localparam int    ScratchDigits = 2 * MAX_BYTES + 2;
   localparam string DigitChars    =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   typedef struct packed {
      logic [6:0] char_code;
      logic       last_char;
      logic       overflow;
   } b58_char_type;

   logic [7:0]   held_bytes [MAX_BYTES];
   int unsigned  held_count;
   int unsigned  lead_zeros;
   bit           bytes_dropped;
   b58_char_type due_chars [$];

   // repeated long division by 58, characters queued most significant first
   function automatic void queue_encoding();
      logic [7:0]   work [MAX_BYTES];
      logic [5:0]   lsd_first [$];
      int unsigned  rem, dividend, total, nd, i, k;
      bit           nonzero, cut;
      byte          ascii;
      b58_char_type ch;
      for (i = 0; i < held_count; i++) work[i] = held_bytes[i];
      forever begin
         nonzero = 1'b0;
         for (i = 0; i < held_count; i++) if (work[i] != 8'd0) nonzero = 1'b1;
         if (!nonzero || lsd_first.size() >= ScratchDigits) break;
         rem = 0;
         for (i = 0; i < held_count; i++) begin
            dividend = (rem << 8) | work[i];
            work[i]  = 8'(dividend / b58_pkg::Radix);
            rem      = dividend % b58_pkg::Radix;
         end
         lsd_first = {lsd_first, 6'(rem)};
      end
      nd    = lsd_first.size();
      total = lead_zeros + nd;
      cut   = 1'b0;
      if (total > MAX_DIGITS) begin
         total = MAX_DIGITS;
         cut   = 1'b1;
      end
      for (k = 0; k < total; k++) begin
         if (k < lead_zeros) begin
            ch.char_code = b58_pkg::CharOne;
         end else begin
            ascii        = DigitChars[lsd_first[nd - 1 - (k - lead_zeros)]];
            ch.char_code = ascii[6:0];
         end
         ch.last_char = (k + 1 == total);
         ch.overflow  = bytes_dropped | cut;
         due_chars    = {due_chars, ch};
      end
   endfunction

   always @(posedge clock) begin
      b58_char_type want;
      if (reset) begin
         held_count    = 0;
         lead_zeros    = 0;
         bytes_dropped = 1'b0;
         fail_count    = 0;
         due_chars.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_chars.size() == 0) begin
               $error("char_code 0x%02h arrived with no character due", rsp_mon.char_code);
               fail_count++;
            end else begin
               want = due_chars.pop_front();
               if (rsp_mon.char_code !== want.char_code) begin
                  $error("char_code: expected 0x%02h, got 0x%02h",
                         want.char_code, rsp_mon.char_code);
                  fail_count++;
               end
               if (rsp_mon.last_char !== want.last_char) begin
                  $error("last_char: expected %0b, got %0b", want.last_char, rsp_mon.last_char);
                  fail_count++;
               end
               if (rsp_mon.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_mon.overflow);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (held_count < MAX_BYTES) begin
               if (req_mon.data_byte == 8'd0 && lead_zeros == held_count) lead_zeros++;
               held_bytes[held_count] = req_mon.data_byte;
               held_count++;
            end else begin
               bytes_dropped = 1'b1;
            end
            if (req_mon.last_byte) begin
               queue_encoding();
               held_count    = 0;
               lead_zeros    = 0;
               bytes_dropped = 1'b0;
            end
         end
      end
      chars_owed = due_chars.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// testbench top for the base58 encoder: clock, reset, byte stimulus and verdict
`timescale 1ns / 100ps

module tb_top;

   localparam int MaxBytes     = b58_pkg::MaxBytesDefault;
   localparam int PhaseItems   = 115;        // random bytes per idling phase
   localparam int SettleCycles = 100;        // quiet time after the last character
   localparam int CycleLimit   = 4_000_000;  // several times the slowest legal run

   logic        clock;
   logic        reset;
   int          send_idle_pct = 25;
   int          take_idle_pct = 87;
   int          bytes_sent    = 0;
   int          fail_count;
   int          chars_owed;
   int unsigned cycle_count   = 0;

   b58_req_if req_bus ();
   b58_rsp_if rsp_bus ();

   base58_encoder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // watches both channels, predicts every character and counts mismatches
   b58_char_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .chars_owed (chars_owed)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: ready is redrawn every cycle from the current idling rate
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= take_idle_pct);
      end
   end

   // one byte transaction, with random idle cycles in front of it;
   // ready is sampled at the edge, before any update made there
   task automatic send_byte(input logic [7:0] value, input logic is_last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      req_bus.last_byte <= is_last;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
   endtask

   // a whole string, the final byte marked last
   task automatic send_string(input logic [7:0] str [$]);
      int i;
      for (i = 0; i < str.size(); i++) send_byte(str[i], i == str.size() - 1);
   endtask

   // sender holds off until every predicted character has been taken;
   // sampled on the falling edge so the checker has already updated
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (chars_owed != 0);
      @(posedge clock);
   endtask

   // random strings: mostly well-formed strings of varied shape, plus
   // strings that spill past the store and strings of zeros only
   task automatic send_random_strings(input int budget);
      logic [7:0] str [$];
      int         stop_at, kind, len, zeros, i;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         str.delete();
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            // general string with a short run of leading zero bytes
            len   = $urandom_range(1, MaxBytes);
            zeros = $urandom_range(0, 3);
            for (i = 0; i < len; i++) str = {str, (i < zeros ? 8'h00 : 8'($urandom))};
         end else if (kind < 67) begin
            // address shaped: version, 20-byte payload, 4 check bytes
            str = {str, (kind[0] ? 8'h00 : 8'($urandom))};
            for (i = 0; i < 24; i++) str = {str, 8'($urandom)};
         end else if (kind < 75) begin
            // full store, often all ones for the longest encoding
            for (i = 0; i < MaxBytes; i++) str = {str, (kind[0] ? 8'hff : 8'($urandom))};
         end else if (kind < 83) begin
            // bytes beyond the store, the marked one among the dropped
            len = $urandom_range(MaxBytes + 1, MaxBytes + 8);
            for (i = 0; i < len; i++) begin
               str = {str, ((kind[0] && i == 0) ? 8'h00 : 8'($urandom))};
            end
         end else if (kind < 90) begin
            // zeros only, now and then past the store
            len = $urandom_range(1, MaxBytes + 2);
            for (i = 0; i < len; i++) str = {str, 8'h00};
         end else begin
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++) str = {str, 8'($urandom)};
         end
         send_string(str);
      end
   endtask

   initial begin : stimulus
      logic [7:0] str [$];
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      reset             <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles a quarter of the time, receiver mostly stalls
      send_idle_pct = 25;
      take_idle_pct = 87;

      // directed strings
      str = '{8'h00};                          // single zero byte
      send_string(str);
      str = '{8'hff};                          // single byte, all ones
      send_string(str);
      str = '{8'h39};                          // highest single digit
      send_string(str);
      str = '{8'h3a};                          // first two-digit value
      send_string(str);
      str = '{8'h00, 8'h00, 8'h01};            // leading zero bytes then a digit
      send_string(str);
      str = '{8'h00, 8'h00, 8'h00, 8'h00};     // zeros only
      send_string(str);
      str = '{8'h01, 8'h00};                   // zero byte that is not leading
      send_string(str);
      str = '{8'h80, 8'h7f, 8'hff};            // mixed bit patterns
      send_string(str);
      str = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h55, 8'haa};
      send_string(str);
      wait_drained();

      send_random_strings(PhaseItems);
      wait_drained();

      // phase two: idling rates swapped
      send_idle_pct = 87;
      take_idle_pct = 25;
      send_random_strings(PhaseItems);
      wait_drained();

      // phase three: back to back, no idling
      send_idle_pct = 0;
      take_idle_pct = 0;
      send_random_strings(PhaseItems);
      wait_drained();

      // anything arriving now has no prediction and is caught by the checker
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- base58_encoder.f -----
+incdir+sv
sv/b58_pkg.sv
sv/b58_if.sv
sv/b58_divstep.sv
sv/base58_encoder.sv
tb/b58_char_checker.sv
tb/tb_top.sv
